// File: design/dynamic_arrive_steering_top_defines.svh
// assertion macros shared by the arrive steering design
`ifndef DYNAMIC_ARRIVE_STEERING_TOP_DEFINES_SVH
`define DYNAMIC_ARRIVE_STEERING_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define DAS_CHECK(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("das check failed");

// next-cycle implication, checked outside reset
`define DAS_CHECK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("das check failed");

`endif

// File: design/das_pkg.sv
// shared constants and register codes for the arrive steering block
`timescale 1ns / 1ps
`default_nettype none
package das_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int CFG_W         = 31;
    localparam int CFG_IDX_W     = 3;
    localparam int COORD_W       = 32;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_SPEED      = 3'd0,
        CFG_MAX_ACCEL      = 3'd1,
        CFG_TARGET_RADIUS  = 3'd2,
        CFG_SLOW_RADIUS    = 3'd3,
        CFG_TIME_TO_TARGET = 3'd4
    } t_cfg_idx;

    localparam logic [CFG_W-1:0] RST_MAX_SPEED      = 31'd65536;
    localparam logic [CFG_W-1:0] RST_MAX_ACCEL      = 31'd65536;
    localparam logic [CFG_W-1:0] RST_TARGET_RADIUS  = 31'd65536;
    localparam logic [CFG_W-1:0] RST_SLOW_RADIUS    = 31'd655360;
    localparam logic [CFG_W-1:0] RST_TIME_TO_TARGET = 31'd6554;

    // stage-to-stage control: advance strobe and item valid
    typedef struct packed {
        logic en;
        logic valid;
    } t_pipe_ctl;

endpackage
`default_nettype wire

// File: design/das_div.sv
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
`default_nettype none
module das_div #(
    parameter int NUM_W  = 62,
    parameter int DEN_W  = 31,
    parameter int QUO_W  = 31,
    parameter int SIDE_W = 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire das_pkg::t_pipe_ctl i_ctl,
    input  wire logic [NUM_W-1:0]  i_num,
    input  wire logic [DEN_W-1:0]  i_den,
    input  wire logic [SIDE_W-1:0] i_side,
    output logic                   o_valid,
    output logic [QUO_W-1:0]       o_quo,
    output logic [SIDE_W-1:0]      o_side
);
    localparam int WIDE_W = NUM_W + DEN_W;

    logic [WIDE_W-1:0] w_num_hi;
    logic [DEN_W-1:0]  w_rem_in  [QUO_W];
    logic [QUO_W-1:0]  w_work_in [QUO_W];
    logic [DEN_W-1:0]  w_den_in  [QUO_W];
    logic [SIDE_W-1:0] w_side_in [QUO_W];
    logic [QUO_W-1:0]  w_valid_in;

    logic [DEN_W-1:0]  r_rem  [QUO_W];
    logic [QUO_W-1:0]  r_work [QUO_W];
    logic [DEN_W-1:0]  r_den  [QUO_W];
    logic [SIDE_W-1:0] r_side [QUO_W];
    logic [QUO_W-1:0]  r_valid;

    // dividend bits above the quotient width seed the remainder
    assign w_num_hi = WIDE_W'(i_num) >> QUO_W;

    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        logic [DEN_W:0]   w_trial;
        logic [DEN_W:0]   w_diff;
        logic             w_ge;
        logic [DEN_W-1:0] n_rem;
        logic [QUO_W-1:0] n_work;

        if (k == 0) begin : g_first
            assign w_rem_in[k]  = w_num_hi[DEN_W-1:0];
            assign w_work_in[k] = i_num[QUO_W-1:0];
            assign w_den_in[k]  = i_den;
            assign w_side_in[k] = i_side;
            assign w_valid_in[k] = i_ctl.valid;
        end else begin : g_next
            assign w_rem_in[k]  = r_rem[k-1];
            assign w_work_in[k] = r_work[k-1];
            assign w_den_in[k]  = r_den[k-1];
            assign w_side_in[k] = r_side[k-1];
            assign w_valid_in[k] = r_valid[k-1];
        end

        // trial subtract of the divisor
        always_comb begin
            w_trial = {w_rem_in[k], w_work_in[k][QUO_W-1]};
            w_diff  = w_trial - {1'b0, w_den_in[k]};
            w_ge    = (w_trial >= {1'b0, w_den_in[k]});
            n_rem   = w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
            n_work  = {w_work_in[k][QUO_W-2:0], w_ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_ctl.en) begin
                r_valid[k] <= w_valid_in[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                r_rem[k]  <= n_rem;
                r_work[k] <= n_work;
                r_den[k]  <= w_den_in[k];
                r_side[k] <= w_side_in[k];
            end
        end
    end

    assign o_valid = r_valid[QUO_W-1];
    assign o_quo   = r_work[QUO_W-1];
    assign o_side  = r_side[QUO_W-1];

endmodule
`default_nettype wire

// File: design/das_isqrt.sv
// pipelined integer square root, one root bit per stage
`timescale 1ns / 1ps
`default_nettype none
module das_isqrt #(
    parameter int RAD_W  = 66,
    parameter int SIDE_W = 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire das_pkg::t_pipe_ctl i_ctl,
    input  wire logic [RAD_W-1:0]  i_rad,
    input  wire logic [SIDE_W-1:0] i_side,
    output logic                   o_valid,
    output logic [RAD_W/2-1:0]     o_root,
    output logic [SIDE_W-1:0]      o_side
);
    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 1;
    localparam int TRY_W  = ROOT_W + 3;

    logic [REM_W-1:0]  w_rem_in  [ROOT_W];
    logic [RAD_W-1:0]  w_rad_in  [ROOT_W];
    logic [ROOT_W-1:0] w_root_in [ROOT_W];
    logic [SIDE_W-1:0] w_side_in [ROOT_W];
    logic [ROOT_W-1:0] w_valid_in;

    logic [REM_W-1:0]  r_rem  [ROOT_W];
    logic [RAD_W-1:0]  r_rad  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];
    logic [SIDE_W-1:0] r_side [ROOT_W];
    logic [ROOT_W-1:0] r_valid;

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic [TRY_W-1:0]  w_trial;
        logic [TRY_W-1:0]  w_cand;
        logic [TRY_W-1:0]  w_diff;
        logic              w_ge;
        logic [REM_W-1:0]  n_rem;
        logic [ROOT_W-1:0] n_root;

        if (k == 0) begin : g_first
            assign w_rem_in[k]   = '0;
            assign w_rad_in[k]   = i_rad;
            assign w_root_in[k]  = '0;
            assign w_side_in[k]  = i_side;
            assign w_valid_in[k] = i_ctl.valid;
        end else begin : g_next
            assign w_rem_in[k]   = r_rem[k-1];
            assign w_rad_in[k]   = r_rad[k-1];
            assign w_root_in[k]  = r_root[k-1];
            assign w_side_in[k]  = r_side[k-1];
            assign w_valid_in[k] = r_valid[k-1];
        end

        // bring down two radicand bits and try root*4+1
        always_comb begin
            w_trial = {w_rem_in[k], w_rad_in[k][RAD_W-1:RAD_W-2]};
            w_cand  = TRY_W'({w_root_in[k], 2'b01});
            w_diff  = w_trial - w_cand;
            w_ge    = (w_trial >= w_cand);
            n_rem   = w_ge ? w_diff[REM_W-1:0] : w_trial[REM_W-1:0];
            n_root  = {w_root_in[k][ROOT_W-2:0], w_ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_ctl.en) begin
                r_valid[k] <= w_valid_in[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                r_rem[k]  <= n_rem;
                r_rad[k]  <= {w_rad_in[k][RAD_W-3:0], 2'b00};
                r_root[k] <= n_root;
                r_side[k] <= w_side_in[k];
            end
        end
    end

    assign o_valid = r_valid[ROOT_W-1];
    assign o_root  = r_root[ROOT_W-1];
    assign o_side  = r_side[ROOT_W-1];

endmodule
`default_nettype wire

// File: design/das_sqsum.sv
// sum of two squares from split partial products, three stages
`timescale 1ns / 1ps
`default_nettype none
module das_sqsum #(
    parameter int MAG_W  = 32,
    parameter int SIDE_W = 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire das_pkg::t_pipe_ctl i_ctl,
    input  wire logic [MAG_W-1:0]  i_mag_x,
    input  wire logic [MAG_W-1:0]  i_mag_y,
    input  wire logic [SIDE_W-1:0] i_side,
    output logic                   o_valid,
    output logic [2*MAG_W:0]       o_sum,
    output logic [SIDE_W-1:0]      o_side
);
    localparam int LO_W  = (MAG_W + 1) / 2;
    localparam int HI_W  = MAG_W - LO_W;
    localparam int SQ_W  = 2 * MAG_W;
    localparam int SUM_W = 2 * MAG_W + 1;

    logic [2*LO_W-1:0]      r_pll_x, r_pll_y;
    logic [HI_W+LO_W-1:0]   r_phl_x, r_phl_y;
    logic [2*HI_W-1:0]      r_phh_x, r_phh_y;
    logic [SQ_W-1:0]        r_sq_x, r_sq_y;
    logic [SUM_W-1:0]       r_sum;
    logic [SIDE_W-1:0]      r_side1, r_side2, r_side3;
    logic [2:0]             r_valid;

    logic [LO_W-1:0] w_lo_x, w_lo_y;
    logic [HI_W-1:0] w_hi_x, w_hi_y;

    assign w_lo_x = i_mag_x[LO_W-1:0];
    assign w_hi_x = i_mag_x[MAG_W-1:LO_W];
    assign w_lo_y = i_mag_y[LO_W-1:0];
    assign w_hi_y = i_mag_y[MAG_W-1:LO_W];

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_ctl.en) begin
            r_valid <= {r_valid[1:0], i_ctl.valid};
        end
    end

    // partial products, then squares, then the sum
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_pll_x <= (2*LO_W)'(w_lo_x) * (2*LO_W)'(w_lo_x);
            r_pll_y <= (2*LO_W)'(w_lo_y) * (2*LO_W)'(w_lo_y);
            r_phl_x <= (HI_W+LO_W)'(w_hi_x) * (HI_W+LO_W)'(w_lo_x);
            r_phl_y <= (HI_W+LO_W)'(w_hi_y) * (HI_W+LO_W)'(w_lo_y);
            r_phh_x <= (2*HI_W)'(w_hi_x) * (2*HI_W)'(w_hi_x);
            r_phh_y <= (2*HI_W)'(w_hi_y) * (2*HI_W)'(w_hi_y);
            r_side1 <= i_side;

            r_sq_x  <= (SQ_W'(r_phh_x) << (2*LO_W)) + (SQ_W'(r_phl_x) << (LO_W+1))
                       + SQ_W'(r_pll_x);
            r_sq_y  <= (SQ_W'(r_phh_y) << (2*LO_W)) + (SQ_W'(r_phl_y) << (LO_W+1))
                       + SQ_W'(r_pll_y);
            r_side2 <= r_side1;

            r_sum   <= SUM_W'(r_sq_x) + SUM_W'(r_sq_y);
            r_side3 <= r_side2;
        end
    end

    assign o_valid = r_valid[2];
    assign o_sum   = r_sum;
    assign o_side  = r_side3;

endmodule
`default_nettype wire

// File: design/dynamic_arrive_steering_top.sv
// arrive steering for one agent per cycle unless the receiver stalls, deep pipeline top level
//
// Input stream s_axis carries one agent per request: character position,
// goal position and character velocity, signed Q16.16. Output stream m_axis
// returns the steering acceleration per request, x and y in tdata, with the
// arrived and accel-limited flags in tuser. Results leave in request order.
// The config channel (i_cfg_valid/o_cfg_ready) writes max_speed, max_accel,
// target_radius, slow_radius and time_to_target by index; o_cfg_ready is
// always high, and writes belong in idle periods.
// Throughput is one request per cycle while the receiver does not stall the
// pipeline. The pipeline depth is set by the bit-per-stage square roots and dividers:
// distance root 33, speed divide 31, target velocity divide 31, time divide
// 32+FRAC_BITS, acceleration root 33+FRAC_BITS, clamp divide 31.
// Reset clears every valid bit and restores the register defaults.
// When the receiver holds m_axis_tready low with a result waiting, the whole
// pipeline freezes and s_axis_tready drops; nothing is dropped or repeated.
`timescale 1ns / 1ps
`default_nettype none
`include "dynamic_arrive_steering_top_defines.svh"
module dynamic_arrive_steering_top #(
    parameter int FRAC_BITS = das_pkg::FRAC_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // lowest bit up: char_pos_x, char_pos_y, goal_pos_x, goal_pos_y,
    // char_vel_x, char_vel_y (32 bits each)
    input  wire logic [191:0]                   s_axis_tdata,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // lowest bit up: accel_x, accel_y (32 bits each)
    output logic [63:0]                         m_axis_tdata,
    // lowest bit up: arrived, accel_limited
    output logic [1:0]                          m_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [das_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [31:0]                    i_cfg_data
);
    localparam int CW    = das_pkg::CFG_W;
    localparam int A_W   = 32 + FRAC_BITS;
    localparam int H2    = (A_W + 1) / 2;
    localparam int HI2   = A_W - H2;
    localparam int NF_W  = A_W + CW;
    localparam int SA_W  = 130;
    localparam int SS_W  = 166;
    localparam int SB_W  = 3 + 2 * A_W;

    // configuration registers
    logic [CW-1:0] r_max_speed, r_max_accel, r_target_radius, r_slow_radius, r_ttt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_speed     <= das_pkg::RST_MAX_SPEED;
            r_max_accel     <= das_pkg::RST_MAX_ACCEL;
            r_target_radius <= das_pkg::RST_TARGET_RADIUS;
            r_slow_radius   <= das_pkg::RST_SLOW_RADIUS;
            r_ttt           <= das_pkg::RST_TIME_TO_TARGET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                das_pkg::CFG_MAX_SPEED:      r_max_speed     <= i_cfg_data[CW-1:0];
                das_pkg::CFG_MAX_ACCEL:      r_max_accel     <= i_cfg_data[CW-1:0];
                das_pkg::CFG_TARGET_RADIUS:  r_target_radius <= i_cfg_data[CW-1:0];
                das_pkg::CFG_SLOW_RADIUS:    r_slow_radius   <= i_cfg_data[CW-1:0];
                das_pkg::CFG_TIME_TO_TARGET: r_ttt           <= i_cfg_data[CW-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // global advance: the output register is free or being taken
    logic r_out_valid;
    logic w_en;
    assign w_en          = !r_out_valid || m_axis_tready;
    assign s_axis_tready = w_en;

    // stage 1: offsets to the goal and their magnitudes
    logic signed [32:0] w_dx, w_dy;
    logic        r1_valid, r1_sx, r1_sy;
    logic [31:0] r1_magx, r1_magy, r1_vx, r1_vy;

    assign w_dx = $signed({s_axis_tdata[95], s_axis_tdata[95:64]})
                - $signed({s_axis_tdata[31], s_axis_tdata[31:0]});
    assign w_dy = $signed({s_axis_tdata[127], s_axis_tdata[127:96]})
                - $signed({s_axis_tdata[63], s_axis_tdata[63:32]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (w_en) begin
            r1_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_sx   <= w_dx[32];
            r1_sy   <= w_dy[32];
            r1_magx <= w_dx[32] ? 32'(-w_dx) : w_dx[31:0];
            r1_magy <= w_dy[32] ? 32'(-w_dy) : w_dy[31:0];
            r1_vx   <= s_axis_tdata[159:128];
            r1_vy   <= s_axis_tdata[191:160];
        end
    end

    // distance: sum of squares then root
    logic            w_sqa_valid;
    logic [64:0]     w_sqa_sum;
    logic [SA_W-1:0] w_sqa_side;

    das_sqsum #(.MAG_W(32), .SIDE_W(SA_W)) u_sq_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   ('{en: w_en, valid: r1_valid}),
        .i_mag_x (r1_magx),
        .i_mag_y (r1_magy),
        .i_side  ({r1_sx, r1_sy, r1_magx, r1_magy, r1_vx, r1_vy}),
        .o_valid (w_sqa_valid),
        .o_sum   (w_sqa_sum),
        .o_side  (w_sqa_side)
    );

    logic            w_dist_valid;
    logic [32:0]     w_dist;
    logic [SA_W-1:0] w_dist_side;

    das_isqrt #(.RAD_W(66), .SIDE_W(SA_W)) u_root_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   ('{en: w_en, valid: w_sqa_valid}),
        .i_rad   ({1'b0, w_sqa_sum}),
        .i_side  (w_sqa_side),
        .o_valid (w_dist_valid),
        .o_root  (w_dist),
        .o_side  (w_dist_side)
    );

    // stage 2: arrival and slowing zone decisions
    logic            r2_valid, r2_arrived, r2_gt_slow, r2_dist_nz;
    logic [CW-1:0]   r2_dmin;
    logic [32:0]     r2_dist;
    logic [SA_W-1:0] r2_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (w_en) begin
            r2_valid <= w_dist_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_arrived <= (w_dist < 33'(r_target_radius));
            r2_gt_slow <= (w_dist > 33'(r_slow_radius));
            r2_dist_nz <= (w_dist != '0);
            r2_dmin    <= (w_dist > 33'(r_slow_radius)) ? r_slow_radius : w_dist[CW-1:0];
            r2_dist    <= w_dist;
            r2_side    <= w_dist_side;
        end
    end

    // stage 3: max_speed times clipped distance
    logic            r3_valid, r3_arrived, r3_gt_slow, r3_dist_nz;
    logic [61:0]     r3_prod;
    logic [32:0]     r3_dist;
    logic [SA_W-1:0] r3_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (w_en) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_prod    <= 62'(r_max_speed) * 62'(r2_dmin);
            r3_arrived <= r2_arrived;
            r3_gt_slow <= r2_gt_slow;
            r3_dist_nz <= r2_dist_nz;
            r3_dist    <= r2_dist;
            r3_side    <= r2_side;
        end
    end

    // speed inside the slowing zone
    logic            w_spd_valid;
    logic [CW-1:0]   w_spd_q;
    logic [SS_W-1:0] w_spd_side;

    das_div #(.NUM_W(62), .DEN_W(CW), .QUO_W(CW), .SIDE_W(SS_W)) u_div_speed (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   ('{en: w_en, valid: r3_valid}),
        .i_num   (r3_prod),
        .i_den   (r_slow_radius),
        .i_side  ({r3_arrived, r3_gt_slow, r3_dist_nz, r3_dist, r3_side}),
        .o_valid (w_spd_valid),
        .o_quo   (w_spd_q),
        .o_side  (w_spd_side)
    );

    // stage 4: select target speed
    logic            r4_valid, r4_arrived, r4_dist_nz;
    logic [CW-1:0]   r4_speed;
    logic [32:0]     r4_dist;
    logic [SA_W-1:0] r4_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (w_en) begin
            r4_valid <= w_spd_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            priority if (w_spd_side[164]) begin
                r4_speed <= r_max_speed;
            end else if (r_slow_radius == '0) begin
                r4_speed <= '0;
            end else begin
                r4_speed <= w_spd_q;
            end
            r4_arrived <= w_spd_side[165];
            r4_dist_nz <= w_spd_side[163];
            r4_dist    <= w_spd_side[162:130];
            r4_side    <= w_spd_side[SA_W-1:0];
        end
    end

    // stage 5: offset times speed
    logic        r5_valid, r5_arrived, r5_dist_nz, r5_sx, r5_sy;
    logic [62:0] r5_px, r5_py;
    logic [32:0] r5_dist;
    logic [31:0] r5_vx, r5_vy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else if (w_en) begin
            r5_valid <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_px      <= 63'(r4_side[127:96]) * 63'(r4_speed);
            r5_py      <= 63'(r4_side[95:64]) * 63'(r4_speed);
            r5_arrived <= r4_arrived;
            r5_dist_nz <= r4_dist_nz;
            r5_dist    <= r4_dist;
            r5_sx      <= r4_side[129];
            r5_sy      <= r4_side[128];
            r5_vx      <= r4_side[63:32];
            r5_vy      <= r4_side[31:0];
        end
    end

    // target velocity: offset * speed / distance
    logic          w_tvx_valid, w_tvy_valid;
    logic [CW-1:0] w_tvx_q, w_tvy_q;
    logic [34:0]   w_tvx_side;
    logic [32:0]   w_tvy_side;

    das_div #(.NUM_W(63), .DEN_W(33), .QUO_W(CW), .SIDE_W(35)) u_div_tvx (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   ('{en: w_en, valid: r5_valid}),
        .i_num   (r5_px),
        .i_den   (r5_dist),
        .i_side  ({r5_arrived, r5_dist_nz, r5_sx, r5_vx}),
        .o_valid (w_tvx_valid),
        .o_quo   (w_tvx_q),
        .o_side  (w_tvx_side)
    );

    das_div #(.NUM_W(63), .DEN_W(33), .QUO_W(CW), .SIDE_W(33)) u_div_tvy (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   ('{en: w_en, valid: r5_valid}),
        .i_num   (r5_py),
        .i_den   (r5_dist),
        .i_side  ({r5_sy, r5_vy}),
        .o_valid (w_tvy_valid),
        .o_quo   (w_tvy_q),
        .o_side  (w_tvy_side)
    );

    // stage 6: signed target velocity, zero without a direction
    logic        r6_valid, r6_arrived;
    logic [31:0] r6_tx, r6_ty, r6_vx, r6_vy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_valid <= 1'b0;
        end else if (w_en) begin
            r6_valid <= w_tvx_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (!w_tvx_side[33]) begin
                r6_tx <= '0;
                r6_ty <= '0;
            end else begin
                r6_tx <= w_tvx_side[32] ? -{1'b0, w_tvx_q} : {1'b0, w_tvx_q};
                r6_ty <= w_tvy_side[32] ? -{1'b0, w_tvy_q} : {1'b0, w_tvy_q};
            end
            r6_arrived <= w_tvx_side[34];
            r6_vx      <= w_tvx_side[31:0];
            r6_vy      <= w_tvy_side[31:0];
        end
    end

    // stage 7: velocity error magnitude and sign
    logic signed [32:0] w_ex, w_ey;
    logic        r7_valid, r7_arrived, r7_sx, r7_sy;
    logic [31:0] r7_emx, r7_emy;

    assign w_ex = $signed({r6_tx[31], r6_tx}) - $signed({r6_vx[31], r6_vx});
    assign w_ey = $signed({r6_ty[31], r6_ty}) - $signed({r6_vy[31], r6_vy});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_valid <= 1'b0;
        end else if (w_en) begin
            r7_valid <= r6_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r7_arrived <= r6_arrived;
            r7_sx      <= w_ex[32];
            r7_sy      <= w_ey[32];
            r7_emx     <= w_ex[32] ? 32'(-w_ex) : w_ex[31:0];
            r7_emy     <= w_ey[32] ? 32'(-w_ey) : w_ey[31:0];
        end
    end

    // acceleration: error scaled by one over time_to_target
    logic [CW-1:0] w_ttt_eff;
    assign w_ttt_eff = (r_ttt == '0) ? CW'(1) : r_ttt;

    logic           w_acx_valid, w_acy_valid;
    logic [A_W-1:0] w_acx_q, w_acy_q;
    logic [1:0]     w_acx_side;
    logic           w_acy_side;

    das_div #(.NUM_W(A_W), .DEN_W(CW), .QUO_W(A_W), .SIDE_W(2)) u_div_acx (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   ('{en: w_en, valid: r7_valid}),
        .i_num   (A_W'(r7_emx) << FRAC_BITS),
        .i_den   (w_ttt_eff),
        .i_side  ({r7_arrived, r7_sx}),
        .o_valid (w_acx_valid),
        .o_quo   (w_acx_q),
        .o_side  (w_acx_side)
    );

    das_div #(.NUM_W(A_W), .DEN_W(CW), .QUO_W(A_W), .SIDE_W(1)) u_div_acy (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   ('{en: w_en, valid: r7_valid}),
        .i_num   (A_W'(r7_emy) << FRAC_BITS),
        .i_den   (w_ttt_eff),
        .i_side  (r7_sy),
        .o_valid (w_acy_valid),
        .o_quo   (w_acy_q),
        .o_side  (w_acy_side)
    );

    // acceleration length
    logic            w_sqb_valid;
    logic [2*A_W:0]  w_sqb_sum;
    logic [SB_W-1:0] w_sqb_side;

    das_sqsum #(.MAG_W(A_W), .SIDE_W(SB_W)) u_sq_accel (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   ('{en: w_en, valid: w_acx_valid}),
        .i_mag_x (w_acx_q),
        .i_mag_y (w_acy_q),
        .i_side  ({w_acx_side, w_acy_side, w_acx_q, w_acy_q}),
        .o_valid (w_sqb_valid),
        .o_sum   (w_sqb_sum),
        .o_side  (w_sqb_side)
    );

    logic            w_len_valid;
    logic [A_W:0]    w_len;
    logic [SB_W-1:0] w_len_side;

    das_isqrt #(.RAD_W(2*A_W+2), .SIDE_W(SB_W)) u_root_accel (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   ('{en: w_en, valid: w_sqb_valid}),
        .i_rad   ({1'b0, w_sqb_sum}),
        .i_side  (w_sqb_side),
        .o_valid (w_len_valid),
        .o_root  (w_len),
        .o_side  (w_len_side)
    );

    // stage 8: clamp decision
    logic            r8_valid, r8_limited;
    logic [A_W:0]    r8_len;
    logic [SB_W-1:0] r8_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_valid <= 1'b0;
        end else if (w_en) begin
            r8_valid <= w_len_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r8_limited <= (w_len > (A_W+1)'(r_max_accel));
            r8_len     <= w_len;
            r8_side    <= w_len_side;
        end
    end

    // stage 9: split products with max_accel
    logic              r9_valid, r9_limited;
    logic [HI2+CW-1:0] r9_mxh, r9_myh;
    logic [H2+CW-1:0]  r9_mxl, r9_myl;
    logic [A_W:0]      r9_len;
    logic [SB_W-1:0]   r9_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r9_valid <= 1'b0;
        end else if (w_en) begin
            r9_valid <= r8_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r9_mxh     <= (HI2+CW)'(r8_side[2*A_W-1:A_W+H2]) * (HI2+CW)'(r_max_accel);
            r9_mxl     <= (H2+CW)'(r8_side[A_W+H2-1:A_W]) * (H2+CW)'(r_max_accel);
            r9_myh     <= (HI2+CW)'(r8_side[A_W-1:H2]) * (HI2+CW)'(r_max_accel);
            r9_myl     <= (H2+CW)'(r8_side[H2-1:0]) * (H2+CW)'(r_max_accel);
            r9_limited <= r8_limited;
            r9_len     <= r8_len;
            r9_side    <= r8_side;
        end
    end

    // stage 10: join the partial products
    logic            r10_valid, r10_limited;
    logic [NF_W-1:0] r10_nx, r10_ny;
    logic [A_W:0]    r10_len;
    logic [SB_W-1:0] r10_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r10_valid <= 1'b0;
        end else if (w_en) begin
            r10_valid <= r9_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r10_nx      <= (NF_W'(r9_mxh) << H2) + NF_W'(r9_mxl);
            r10_ny      <= (NF_W'(r9_myh) << H2) + NF_W'(r9_myl);
            r10_limited <= r9_limited;
            r10_len     <= r9_len;
            r10_side    <= r9_side;
        end
    end

    // clamped components: a * max_accel / length
    logic          w_fvx_valid, w_fvy_valid;
    logic [CW-1:0] w_fvx_q, w_fvy_q;
    logic [33:0]   w_fvx_side;
    logic [31:0]   w_fvy_side;

    das_div #(.NUM_W(NF_W), .DEN_W(A_W+1), .QUO_W(CW), .SIDE_W(34)) u_div_fvx (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   ('{en: w_en, valid: r10_valid}),
        .i_num   (r10_nx),
        .i_den   (r10_len),
        .i_side  ({r10_side[SB_W-1], r10_limited, r10_side[SB_W-2],
                   r10_side[A_W+CW-1:A_W]}),
        .o_valid (w_fvx_valid),
        .o_quo   (w_fvx_q),
        .o_side  (w_fvx_side)
    );

    das_div #(.NUM_W(NF_W), .DEN_W(A_W+1), .QUO_W(CW), .SIDE_W(32)) u_div_fvy (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   ('{en: w_en, valid: r10_valid}),
        .i_num   (r10_ny),
        .i_den   (r10_len),
        .i_side  ({r10_side[SB_W-3], r10_side[CW-1:0]}),
        .o_valid (w_fvy_valid),
        .o_quo   (w_fvy_q),
        .o_side  (w_fvy_side)
    );

    // output register: pick clamped or plain magnitude, apply sign
    logic [CW-1:0] w_magx, w_magy;
    logic [31:0]   r_out_ax, r_out_ay;
    logic          r_out_arrived, r_out_limited;

    assign w_magx = w_fvx_side[32] ? w_fvx_q : w_fvx_side[CW-1:0];
    assign w_magy = w_fvx_side[32] ? w_fvy_q : w_fvy_side[CW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_fvx_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (w_fvx_side[33]) begin
                r_out_ax      <= '0;
                r_out_ay      <= '0;
                r_out_limited <= 1'b0;
            end else begin
                r_out_ax      <= w_fvx_side[31] ? -{1'b0, w_magx} : {1'b0, w_magx};
                r_out_ay      <= w_fvy_side[31] ? -{1'b0, w_magy} : {1'b0, w_magy};
                r_out_limited <= w_fvx_side[32];
            end
            r_out_arrived <= w_fvx_side[33];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_ay, r_out_ax};
    assign m_axis_tuser  = {r_out_limited, r_out_arrived};

    // checks
    `DAS_CHECK(a_lane_sync, i_clk, i_rst_n, 1'b1, (w_fvx_valid == w_fvy_valid) && (w_acx_valid == w_acy_valid) && (w_tvx_valid == w_tvy_valid))
    `DAS_CHECK(a_arrived_zero, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[0], (m_axis_tdata == '0) && !m_axis_tuser[1])
    `DAS_CHECK(a_stall_only_full, i_clk, i_rst_n, !s_axis_tready, m_axis_tvalid && !m_axis_tready)
    `DAS_CHECK_NEXT(a_stall_freeze, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && (r10_len == $past(r10_len)))

endmodule
`default_nettype wire

// File: sim/testbench.sv
// self-checking testbench for the arrive steering block
`timescale 1ns / 1ps
module testbench;

    localparam int FRAC       = 16;
    localparam int LATENCY    = 208 + 2 * FRAC;
    localparam int CYCLE_CAP  = 600000;
    localparam int IDLE_PCT   = 23;

    typedef struct {
        logic signed [31:0] cpx, cpy, gpx, gpy, vx, vy;
    } agent_t;

    typedef struct {
        logic signed [31:0] ax, ay;
        logic               arrived, limited;
    } steer_t;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic [191:0] s_axis_tdata = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [63:0]  m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [2:0]   i_cfg_index = '0;
    logic [31:0]  i_cfg_data = '0;

    // register copies used by the predictor
    logic [30:0]  steer_regs [5];
    steer_t       pending_steer [$];
    int           errors = 0;
    int           cycles = 0;
    int           hold_left = 0;
    bit           calm = 1'b0;

    dynamic_arrive_steering_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("Verification failed");
            $finish;
        end
    end

    // floor of the euclidean length, exact
    function automatic logic [63:0] vec_length(longint x, longint y);
        logic [127:0] sum, root, trial;
        logic [63:0]  mx, my;
        mx = x < 0 ? 64'(-x) : 64'(x);
        my = y < 0 ? 64'(-y) : 64'(y);
        sum = 128'(mx) * 128'(mx) + 128'(my) * 128'(my);
        root = '0;
        for (int b = 63; b >= 0; b--) begin
            trial = root | (128'(1) << b);
            if (trial * trial <= sum) root = trial;
        end
        return root[63:0];
    endfunction

    // sign(a) * floor(|a| * mul / div)
    function automatic longint scale_q(longint a, logic [63:0] mul, logic [63:0] div);
        logic [127:0] q;
        q = (128'(a < 0 ? 64'(-a) : 64'(a)) * 128'(mul)) / 128'(div);
        return a < 0 ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    function automatic logic signed [31:0] clip32(longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic steer_t arrive_steer(agent_t a);
        steer_t      r;
        longint      dx, dy, tx, ty, ax, ay;
        logic [63:0] gap, speed, ttt, len;
        logic [63:0] spd_max, acc_max, rad_t, rad_s, ttt_reg;
        spd_max = 64'(steer_regs[das_pkg::CFG_MAX_SPEED]);
        acc_max = 64'(steer_regs[das_pkg::CFG_MAX_ACCEL]);
        rad_t   = 64'(steer_regs[das_pkg::CFG_TARGET_RADIUS]);
        rad_s   = 64'(steer_regs[das_pkg::CFG_SLOW_RADIUS]);
        ttt_reg = 64'(steer_regs[das_pkg::CFG_TIME_TO_TARGET]);
        dx = longint'(a.gpx) - longint'(a.cpx);
        dy = longint'(a.gpy) - longint'(a.cpy);
        gap = vec_length(dx, dy);
        r = '{ax: '0, ay: '0, arrived: 1'b0, limited: 1'b0};
        if (gap < rad_t) begin
            r.arrived = 1'b1;
            return r;
        end
        if (gap > rad_s)
            speed = spd_max;
        else if (rad_s == 0)
            speed = '0;
        else
            speed = spd_max * gap / rad_s;
        tx = 0;
        ty = 0;
        if (gap != 0) begin
            tx = scale_q(dx, speed, gap);
            ty = scale_q(dy, speed, gap);
        end
        ttt = ttt_reg != 0 ? ttt_reg : 64'd1;
        ax = scale_q(tx - longint'(a.vx), 64'd1 << FRAC, ttt);
        ay = scale_q(ty - longint'(a.vy), 64'd1 << FRAC, ttt);
        len = vec_length(ax, ay);
        if (len > acc_max) begin
            ax = scale_q(ax, acc_max, len);
            ay = scale_q(ay, acc_max, len);
            r.limited = 1'b1;
        end
        r.ax = clip32(ax);
        r.ay = clip32(ay);
        return r;
    endfunction

    // receiver: random stalls, long hold-off on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left = hold_left - 1;
            end else begin
                m_axis_tready <= calm ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        steer_t exp_s;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_steer.size() == 0) begin
                $display("%0t: unexpected result %h / %b", $time, m_axis_tdata, m_axis_tuser);
                errors++;
            end else begin
                exp_s = pending_steer.pop_front();
                if (m_axis_tdata[31:0] !== exp_s.ax) begin
                    $display("%0t: accel_x expected %0d actual %0d", $time, exp_s.ax,
                             $signed(m_axis_tdata[31:0]));
                    errors++;
                end
                if (m_axis_tdata[63:32] !== exp_s.ay) begin
                    $display("%0t: accel_y expected %0d actual %0d", $time, exp_s.ay,
                             $signed(m_axis_tdata[63:32]));
                    errors++;
                end
                if (m_axis_tuser[0] !== exp_s.arrived) begin
                    $display("%0t: arrived expected %b actual %b", $time, exp_s.arrived,
                             m_axis_tuser[0]);
                    errors++;
                end
                if (m_axis_tuser[1] !== exp_s.limited) begin
                    $display("%0t: accel_limited expected %b actual %b", $time,
                             exp_s.limited, m_axis_tuser[1]);
                    errors++;
                end
            end
        end
    end

    // one agent request; entered and left at a falling edge
    task automatic send_agent(agent_t a);
        if (!calm) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                s_axis_tvalid <= 1'b0;
                @(negedge i_clk);
            end
        end
        s_axis_tdata  <= {a.vy, a.vx, a.gpy, a.gpx, a.cpy, a.cpx};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_steer.push_back(arrive_steer(a));
        @(negedge i_clk);
    endtask

    // register write once the pipeline has drained
    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        s_axis_tvalid <= 1'b0;
        wait (pending_steer.size() == 0);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx <= das_pkg::CFG_TIME_TO_TARGET) steer_regs[idx] = value[30:0];
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_all(logic [30:0] spd, logic [30:0] acc, logic [30:0] tr,
                           logic [30:0] sr, logic [30:0] tt);
        // top bit is junk the block must ignore
        write_reg(das_pkg::CFG_MAX_SPEED,      {1'($urandom), spd});
        write_reg(das_pkg::CFG_MAX_ACCEL,      {1'($urandom), acc});
        write_reg(das_pkg::CFG_TARGET_RADIUS,  {1'($urandom), tr});
        write_reg(das_pkg::CFG_SLOW_RADIUS,    {1'($urandom), sr});
        write_reg(das_pkg::CFG_TIME_TO_TARGET, {1'($urandom), tt});
    endtask

    // mostly nearby goals at a random scale, some fully random agents
    function automatic agent_t rand_agent();
        agent_t a;
        int     sh;
        a.cpx = $urandom;
        a.cpy = $urandom;
        a.gpx = $urandom;
        a.gpy = $urandom;
        a.vx  = $urandom;
        a.vy  = $urandom;
        if ($urandom_range(99) < 75) begin
            sh = $urandom_range(30, 4);
            a.gpx = a.cpx + ($signed($urandom) >>> (32 - sh));
            a.gpy = a.cpy + ($signed($urandom) >>> (32 - sh));
            a.vx  = $signed($urandom) >>> (32 - $urandom_range(31, 4));
            a.vy  = $signed($urandom) >>> (32 - $urandom_range(31, 4));
        end
        return a;
    endfunction

    function automatic agent_t mk(longint cx, longint cy, longint gx, longint gy,
                                  longint vx, longint vy);
        agent_t a;
        a.cpx = cx[31:0]; a.cpy = cy[31:0]; a.gpx = gx[31:0];
        a.gpy = gy[31:0]; a.vx = vx[31:0];  a.vy = vy[31:0];
        return a;
    endfunction

    task automatic random_burst(int n);
        repeat (n) send_agent(rand_agent());
    endtask

    // corners at reset settings, then at extreme register settings
    task automatic test_directed();
        calm = 1'b1;
        send_agent(mk(0, 0, 0, 0, 0, 0));                     // zero distance
        send_agent(mk(0, 0, 0, 0, 32'h7fffffff, 32'h80000000));
        send_agent(mk(0, 0, 65535, 0, 100, -100));            // just inside arrival
        send_agent(mk(0, 0, 65536, 0, 0, 0));                 // on the arrival edge
        send_agent(mk(0, 0, 0, 655360, 0, 0));                // on the slowing edge
        send_agent(mk(0, 0, 327680, -327680, 0, 0));          // slowing zone
        send_agent(mk(0, 0, 655361, 0, 0, 0));                // beyond slowing
        send_agent(mk(-2147483648, -2147483648, 2147483647, 2147483647, 0, 0));
        send_agent(mk(2147483647, -2147483648, -2147483648, 2147483647,
                      -2147483648, 2147483647));
        send_agent(mk(1000, 1000, 1000 + 131072, 1000, 65536, 0));
        send_agent(mk(0, 0, 200000, 200000, 2147483647, 2147483647));
        send_agent(mk(5, 5, -900000, 800000, -2147483648, -2147483648));
        calm = 1'b0;
        // zero target radius, zero slow radius, zero time
        set_all(31'd65536, 31'h7fffffff, 31'd0, 31'd0, 31'd0);
        send_agent(mk(0, 0, 0, 0, 0, 0));
        send_agent(mk(0, 0, 1, 0, 3, -7));
        send_agent(mk(0, 0, 400000, 300000, 0, 0));
        send_agent(mk(-2147483648, 0, 2147483647, 0, -2147483648, 2147483647));
        set_all(31'd0, 31'd0, 31'd0, 31'd1, 31'd1);
        send_agent(mk(0, 0, 70000, 0, 1, 0));
        send_agent(mk(0, 0, 70000, 0, 0, 0));
        set_all(31'h7fffffff, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff);
        send_agent(mk(-2147483648, -2147483648, 2147483647, 2147483647, 0, 0));
        send_agent(mk(0, 0, 2147483647, 0, -2147483648, 0));
        send_agent(mk(0, 0, 1, 1, 0, 0));
        write_reg(3'($urandom_range(7, 5)), $urandom);         // unused index
        send_agent(mk(-2147483648, -2147483648, 2147483647, 2147483647, 7, 7));
    endtask

    // several register settings, extremes included
    task automatic test_config_sweep();
        set_all(31'd65536, 31'd65536, 31'd65536, 31'd655360, 31'd6554);
        random_burst(150);
        set_all(31'h7fffffff, 31'd1, 31'd0, 31'd1, 31'd1);
        random_burst(100);
        set_all(31'd0, 31'h7fffffff, 31'd1 << 20, 31'h7fffffff, 31'd65536);
        random_burst(100);
        for (int k = 0; k < 4; k++) begin
            set_all(31'($urandom) >> $urandom_range(20, 0), 31'($urandom) >> $urandom_range(20, 0),
                    31'($urandom) >> $urandom_range(30, 8), 31'($urandom) >> $urandom_range(20, 0),
                    31'($urandom) >> $urandom_range(28, 4));
            random_burst(100);
        end
    endtask

    // long receiver hold-off while requests keep coming
    task automatic test_backpressure();
        set_all(31'd131072, 31'd98304, 31'd65536, 31'd655360, 31'd6554);
        calm = 1'b1;
        hold_left = 600;
        random_burst(350);
        calm = 1'b0;
    endtask

    // random traffic with a stretch of no idling
    task automatic test_random();
        random_burst(350);
        calm = 1'b1;
        random_burst(150);
        calm = 1'b0;
        random_burst(100);
    endtask

    initial begin
        steer_regs[das_pkg::CFG_MAX_SPEED]      = das_pkg::RST_MAX_SPEED;
        steer_regs[das_pkg::CFG_MAX_ACCEL]      = das_pkg::RST_MAX_ACCEL;
        steer_regs[das_pkg::CFG_TARGET_RADIUS]  = das_pkg::RST_TARGET_RADIUS;
        steer_regs[das_pkg::CFG_SLOW_RADIUS]    = das_pkg::RST_SLOW_RADIUS;
        steer_regs[das_pkg::CFG_TIME_TO_TARGET] = das_pkg::RST_TIME_TO_TARGET;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_config_sweep();
        test_backpressure();
        test_random();
        s_axis_tvalid <= 1'b0;
        wait (pending_steer.size() == 0);
        repeat (LATENCY + 50) @(posedge i_clk);
        if (errors == 0 && pending_steer.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+design
design/das_pkg.sv
design/das_div.sv
design/das_isqrt.sv
design/das_sqsum.sv
design/dynamic_arrive_steering_top.sv
sim/testbench.sv
